### hw/rtl/double_ended_queue_unit_assert.svh
// Assertion macros for the double-ended queue unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Consequent holds in the same cycle as the antecedent.
`define DQU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define DQU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DQU_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define DQU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### hw/rtl/dqu_pkg.sv
package dqu_pkg;

    localparam int DataW     = 32;
    localparam int ModeW     = 3;
    localparam int StatusW   = 2;
    localparam int CntW      = 7;
    localparam int DepthDflt = 64;

    typedef enum logic [ModeW-1:0] {
        MODE_ADD_FRONT    = 3'd0,
        MODE_ADD_REAR     = 3'd1,
        MODE_REMOVE_FRONT = 3'd2,
        MODE_REMOVE_REAR  = 3'd3,
        MODE_LIST         = 3'd4
    } mode_t;

    typedef enum logic [StatusW-1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_REAR,
        CELL_POP_FRONT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [CntW-1:0]   count;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

endpackage

### hw/rtl/dqu_cell.sv
module dqu_cell #(
    parameter int INDEX = 0
) (
    input  logic                       aclk,
    input  dqu_pkg::cell_ctl_t         ctl,
    input  logic [dqu_pkg::DataW-1:0]  in_word,
    input  logic [dqu_pkg::DataW-1:0]  left_word,
    input  logic [dqu_pkg::DataW-1:0]  right_word,
    input  logic [dqu_pkg::DataW-1:0]  wrap_word,
    output logic [dqu_pkg::DataW-1:0]  data
);

    localparam logic [dqu_pkg::CntW-1:0] Pos     = dqu_pkg::CntW'(INDEX);
    localparam logic [dqu_pkg::CntW-1:0] PosNext = dqu_pkg::CntW'(INDEX + 1);

    logic [dqu_pkg::DataW-1:0] data_reg;
    logic [dqu_pkg::DataW-1:0] data_next;

    always_comb begin
        unique case (ctl.op)
            dqu_pkg::CELL_PUSH_FRONT: begin
                data_next = (INDEX == 0) ? in_word : left_word;
            end
            dqu_pkg::CELL_PUSH_REAR: begin
                data_next = (ctl.count == Pos) ? in_word : data_reg;
            end
            dqu_pkg::CELL_POP_FRONT: begin
                data_next = right_word;
            end
            dqu_pkg::CELL_ROTATE: begin
                if (ctl.count == PosNext) begin
                    data_next = wrap_word;
                end else if (ctl.count > PosNext) begin
                    data_next = right_word;
                end else begin
                    data_next = data_reg;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### hw/rtl/double_ended_queue_unit.sv
// Channel | Dir | tdata            | tuser              | tlast
// s_      | in  | [31:0] value     | [2:0] mode         | -
// m_      | out | [31:0] value_res | [1:0] status       | last
//
// Add and remove register their result directly; a list holds the input and
// emits each stored word by one rotation step of the cell chain per result.
// Storage is a row of DEPTH cells, cell 0 the front; a list rotates the
// occupied cells once around and leaves them in their original order.
// Reset (aresetn low, synchronous) empties the queue and clears m_tvalid.
// s_tready is low during reset, during a list and while a result waits in the
// output register; the output register holds until m_tready.
`include "double_ended_queue_unit_assert.svh"

module double_ended_queue_unit #(
    parameter int DEPTH = dqu_pkg::DepthDflt
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dqu_pkg::DataW-1:0]   s_tdata,   // [31:0] value
    input  logic [dqu_pkg::ModeW-1:0]   s_tuser,   // [2:0] mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dqu_pkg::DataW-1:0]   m_tdata,   // [31:0] value_res
    output logic [dqu_pkg::StatusW-1:0] m_tuser,   // [1:0] status
    output logic                        m_tlast
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] One  = CNT_W'(1);

    dqu_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [dqu_pkg::DataW-1:0]     m_value_reg;
    dqu_pkg::status_t              m_status_reg;
    logic                          m_last_reg;

    logic                          out_free;
    logic                          accept;
    logic                          empty;
    logic                          full;
    logic                          list_last;
    dqu_pkg::mode_t                mode;
    dqu_pkg::cell_op_t             op;
    dqu_pkg::cell_ctl_t            ctl;
    logic                          load;
    logic [dqu_pkg::DataW-1:0]     load_value;
    dqu_pkg::status_t              load_status;
    logic                          load_last;

    logic [dqu_pkg::DataW-1:0]     cell_data [DEPTH];

    assign mode      = dqu_pkg::mode_t'(s_tuser);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == Full);
    assign list_last = (idx_reg == count_reg - One);
    assign s_tready  = aresetn && (state_reg == dqu_pkg::ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dqu_pkg::ST_IDLE: begin
                if (accept && mode == dqu_pkg::MODE_LIST && !empty) begin
                    state_next = dqu_pkg::ST_LIST;
                end
            end
            dqu_pkg::ST_LIST: begin
                if (out_free && list_last) begin
                    state_next = dqu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dqu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        op          = dqu_pkg::CELL_HOLD;
        count_next  = count_reg;
        idx_next    = idx_reg;
        load        = 1'b0;
        load_value  = '0;
        load_status = dqu_pkg::STAT_OK;
        load_last   = 1'b1;
        unique case (state_reg)
            dqu_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (mode) inside
                        dqu_pkg::MODE_ADD_FRONT, dqu_pkg::MODE_ADD_REAR: begin
                            load = 1'b1;
                            if (full) begin
                                load_status = dqu_pkg::STAT_OVER;
                            end else begin
                                op = (mode == dqu_pkg::MODE_ADD_FRONT)
                                   ? dqu_pkg::CELL_PUSH_FRONT : dqu_pkg::CELL_PUSH_REAR;
                                count_next = count_reg + One;
                            end
                        end
                        dqu_pkg::MODE_REMOVE_FRONT, dqu_pkg::MODE_REMOVE_REAR: begin
                            load = 1'b1;
                            if (empty) begin
                                load_status = dqu_pkg::STAT_UNDER;
                            end else begin
                                if (mode == dqu_pkg::MODE_REMOVE_FRONT) begin
                                    op = dqu_pkg::CELL_POP_FRONT;
                                end
                                count_next = count_reg - One;
                            end
                        end
                        dqu_pkg::MODE_LIST: begin
                            if (empty) begin
                                load        = 1'b1;
                                load_status = dqu_pkg::STAT_EMPTY;
                            end else begin
                                idx_next = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dqu_pkg::ST_LIST: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_value = cell_data[0];
                    load_last  = list_last;
                    op         = dqu_pkg::CELL_ROTATE;
                    idx_next   = idx_reg + One;
                end
            end
            default: begin
            end
        endcase
    end

    assign ctl.op    = op;
    assign ctl.count = dqu_pkg::CntW'(count_reg);

    always_comb begin
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dqu_pkg::ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_value_reg  <= load_value;
            m_status_reg <= load_status;
            m_last_reg   <= load_last;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [dqu_pkg::DataW-1:0] left_w;
            logic [dqu_pkg::DataW-1:0] right_w;
            if (gi == 0) begin : g_first
                assign left_w = s_tdata;
            end else begin : g_mid_l
                assign left_w = cell_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_w = '0;
            end else begin : g_mid_r
                assign right_w = cell_data[gi+1];
            end
            dqu_cell #(
                .INDEX (gi)
            ) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .in_word    (s_tdata),
                .left_word  (left_w),
                .right_word (right_w),
                .wrap_word  (cell_data[0]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    `DQU_ASSERT_SAME(a_list_blocks_input, aclk, aresetn,
        state_reg == dqu_pkg::ST_LIST, !s_tready)
    `DQU_ASSERT_SAME(a_list_idx_in_range, aclk, aresetn,
        state_reg == dqu_pkg::ST_LIST, idx_reg < count_reg)
    `DQU_ASSERT_NEXT(a_list_ends_idle, aclk, aresetn,
        state_reg == dqu_pkg::ST_LIST && out_free && list_last,
        state_reg == dqu_pkg::ST_IDLE && m_tvalid && m_tlast)
    `DQU_ASSERT_NEXT(a_full_add_overflows, aclk, aresetn,
        accept && full && (mode == dqu_pkg::MODE_ADD_FRONT || mode == dqu_pkg::MODE_ADD_REAR),
        m_tvalid && m_tuser == dqu_pkg::STAT_OVER && count_reg == Full)

endmodule
